FILE: hdl/pss_pkg.sv
// Shared constants and types for the playlist sample selector.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    // Set size and field widths
    localparam int MAX_SAMPLES = 16;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int RND_W       = 15;
    localparam int BITCNT_W    = $clog2(RND_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CNT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ORDER   = 2'd1;

    // Play order codes
    typedef enum logic [1:0] {
        ORDER_SEQ       = 2'd0,
        ORDER_RANDOM    = 2'd1,
        ORDER_NO_REPEAT = 2'd2,
        ORDER_HOLD      = 2'd3
    } play_order_t;

    typedef logic [IDX_W-1:0] pool_entry_t;

endpackage

`default_nettype wire

FILE: hdl/playlist_sample_selector_core.sv
// Playlist sample selector: picks the next sample index per request.
//
//  Channel   Signals                                   Direction  Handshake
//  command   start, random_value                       in         start & !busy
//  result    done, sample_index                        out        done strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         cfg_valid & cfg_ready
//
// In order mode, a count of one or less, or the hold code, the accepting edge
// moves the sequencer to its finishing state, which registers the result strobe.
// Random and no-repeat modes first run the random value through a restoring
// remainder unit, one bit per cycle over its 15 bits, then finish the same way.
// Reset clears control state, sets the count to one and fills the pool with
// identity order. The receiver cannot stall; busy stays high until the strobe.
// Register writes wait while busy or while start is high, so a write never
// lands on the same edge as an accepted transaction.
`timescale 1ns / 1ps
`default_nettype none

module playlist_sample_selector_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [pss_pkg::RND_W-1:0]   random_value,
    output logic                             done,
    output logic [pss_pkg::IDX_W-1:0]        sample_index,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    play_order_t            order_reg, order_next;
    pool_entry_t            pool_reg [MAX_SAMPLES];
    pool_entry_t            pool_next [MAX_SAMPLES];
    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [RND_W-1:0]       rnd_reg, rnd_next;
    logic [CNT_W-1:0]       divisor_reg, divisor_next;
    logic [IDX_W-1:0]       rem_reg, rem_next;
    logic [BITCNT_W-1:0]    bitcnt_reg, bitcnt_next;
    logic                   done_reg, done_next;

    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W-1:0]       eff_depth;
    logic [CNT_W-1:0]       new_eff_count;
    logic [CNT_W-1:0]       rem_shift;
    logic [CNT_W-1:0]       seq_next;
    logic [IDX_W-1:0]       last_pos;
    pool_entry_t            chosen;
    logic                   cmd_accept;
    logic                   cfg_accept;

    // Saturate count and clamp pool depth
    always_comb
    begin
        eff_count = (count_reg > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : count_reg;
        eff_depth = (depth_reg == '0) ? CNT_W'(1) : depth_reg;
        if (eff_depth > eff_count)
        begin
            eff_depth = eff_count;
        end
        new_eff_count = (cfg_data > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : cfg_data;
    end

    assign cmd_accept = start && !busy;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign rem_shift  = {rem_reg, rnd_reg[RND_W-1]};
    assign seq_next   = CNT_W'(cur_reg) + CNT_W'(1);
    assign last_pos   = IDX_W'(eff_count - CNT_W'(1));
    assign chosen     = pool_reg[rem_reg];

    // Sequencer, remainder unit and selection update
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        order_next   = order_reg;
        pool_next    = pool_reg;
        depth_next   = depth_reg;
        cur_next     = cur_reg;
        rnd_next     = rnd_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        bitcnt_next  = bitcnt_reg;
        done_next    = 1'b0;

        // Register writes; a count write refills the pool
        if (cfg_accept)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT:
                begin
                    count_next = cfg_data;
                    for (int i = 0; i < MAX_SAMPLES; i++)
                    begin
                        pool_next[i] = IDX_W'(i);
                    end
                    depth_next = new_eff_count;
                end
                REG_PLAY_ORDER:
                begin
                    order_next = play_order_t'(cfg_data[1:0]);
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    rnd_next    = random_value;
                    rem_next    = '0;
                    bitcnt_next = '0;
                    divisor_next = (order_reg == ORDER_NO_REPEAT) ? eff_depth : eff_count;
                    if (eff_count > CNT_W'(1)
                        && (order_reg == ORDER_RANDOM || order_reg == ORDER_NO_REPEAT))
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                // One restoring step: shift in a bit, subtract if it fits
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                if (rem_shift >= divisor_reg)
                begin
                    rem_next = IDX_W'(rem_shift - divisor_reg);
                end
                else
                begin
                    rem_next = IDX_W'(rem_shift);
                end
                bitcnt_next = bitcnt_reg + BITCNT_W'(1);
                if (bitcnt_reg == BITCNT_W'(RND_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (eff_count <= CNT_W'(1))
                begin
                    cur_next = '0;
                end
                else
                begin
                    case (order_reg)
                        ORDER_SEQ:
                        begin
                            cur_next = (seq_next >= eff_count) ? '0 : IDX_W'(seq_next);
                        end
                        ORDER_RANDOM:
                        begin
                            cur_next = rem_reg;
                        end
                        ORDER_NO_REPEAT:
                        begin
                            // Drop the pick, close the gap, append it at the end
                            for (int i = 0; i < MAX_SAMPLES - 1; i++)
                            begin
                                if (IDX_W'(i) >= rem_reg && CNT_W'(i + 1) < eff_count)
                                begin
                                    pool_next[i] = pool_reg[i + 1];
                                end
                            end
                            pool_next[last_pos] = chosen;
                            cur_next = chosen;
                            if (eff_depth > eff_count - CNT_W'(1))
                            begin
                                depth_next = eff_depth - CNT_W'(1);
                            end
                            else
                            begin
                                depth_next = eff_depth;
                            end
                        end
                        default:
                        begin
                            cur_next = cur_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration, pool and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= CNT_W'(1);
            order_reg  <= ORDER_SEQ;
            depth_reg  <= CNT_W'(1);
            cur_reg    <= '0;
            done_reg   <= 1'b0;
            bitcnt_reg <= '0;
            for (int i = 0; i < MAX_SAMPLES; i++)
            begin
                pool_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            order_reg  <= order_next;
            depth_reg  <= depth_next;
            cur_reg    <= cur_next;
            done_reg   <= done_next;
            bitcnt_reg <= bitcnt_next;
            pool_reg   <= pool_next;
        end
    end

    // Datapath registers of the remainder unit
    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = !busy && !start;
    assign done         = done_reg;
    assign sample_index = cur_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finishing step");

    a_random_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && order_reg == ORDER_RANDOM && eff_count > CNT_W'(1))
        |-> (CNT_W'(rem_reg) < eff_count))
        else $error("remainder not below the sample count");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(MAX_SAMPLES))
        else $error("pool depth above set size");

endmodule

`default_nettype wire
